>>> sv/oledpf_pkg.sv
package oledpf_pkg;

	// default build limits
	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 64;

	// configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

	localparam logic [7:0] ACTIVE_WIDTH_RST  = 8'd128;
	localparam logic [6:0] ACTIVE_HEIGHT_RST = 7'd64;

	// panel command bytes
	localparam logic [7:0] CMD_PAGE     = 8'hb0;
	localparam logic [7:0] CMD_COL_LOW  = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH = 8'h10;

	// colour bits that make a pixel lit
	localparam logic [31:0] LIT_MASK = 32'h00ff_ffff;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_TICK
	} oledpf_state_t;

	typedef struct packed {
		logic take_pix;
		logic take_tick;
		logic clear_wr;
		logic pix_wr;
	} oledpf_cmd_t;

	typedef struct packed {
		logic clear_last;
	} oledpf_status_t;

endpackage

>>> sv/oledpf_ctrl.sv
module oledpf_ctrl import oledpf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           kind,
	output logic           busy,
	output logic           result_strobe,
	output oledpf_cmd_t    cmd,
	input  oledpf_status_t status
);

	oledpf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = kind ? ST_TICK : ST_PIX;
			end
			ST_PIX:  state_d = ST_IDLE;
			ST_TICK: state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy          = 1'b1;
		result_strobe = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_CLEAR: cmd.clear_wr = 1'b1;
			ST_IDLE: begin
				busy          = 1'b0;
				cmd.take_pix  = start && !kind;
				cmd.take_tick = start && kind;
			end
			ST_PIX:  cmd.pix_wr = 1'b1;
			ST_TICK: result_strobe = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

>>> sv/oledpf_dpath.sv
module oledpf_dpath import oledpf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oledpf_cmd_t          cmd,
	output oledpf_status_t       status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic [6:0]           pix_x,
	input  logic [5:0]           pix_y,
	input  logic [31:0]          pixel_word,
	output logic [7:0]           out_byte,
	output logic                 is_command,
	output logic                 end_of_page,
	output logic                 end_of_frame
);

	localparam int MAX_PAGES = MAX_HEIGHT / 8;
	localparam int DEPTH     = MAX_WIDTH * MAX_PAGES;
	localparam int AW        = $clog2(DEPTH);
	localparam int PW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	// sequence counter: three command slots then up to MAX_WIDTH columns
	localparam int SW        = ($clog2(MAX_WIDTH + 4) > 8) ? $clog2(MAX_WIDTH + 4) : 8;

	localparam logic [SW-1:0] SEQ_CMD_PAGE   = SW'(0);
	localparam logic [SW-1:0] SEQ_CMD_COL_LO = SW'(1);
	localparam logic [SW-1:0] SEQ_FIRST_DATA = SW'(3);

	// config registers
	logic [7:0] width_q;
	logic [6:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ACTIVE_WIDTH_RST;
			height_q <= ACTIVE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_data;
				REG_ACTIVE_HEIGHT: height_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clamped geometry
	logic [SW-1:0] w_eff;
	logic [3:0]    pages_raw;
	logic [3:0]    pages_eff;

	always_comb begin
		if (width_q == 8'd0)                     w_eff = SW'(1);
		else if (SW'(width_q) > SW'(MAX_WIDTH))  w_eff = SW'(MAX_WIDTH);
		else                                     w_eff = SW'(width_q);
		pages_raw = height_q[6:3];
		if (pages_raw == 4'd0)                   pages_eff = 4'd1;
		else if (pages_raw > 4'(MAX_PAGES))      pages_eff = 4'(MAX_PAGES);
		else                                     pages_eff = pages_raw;
	end

	// stream position
	logic [PW-1:0] page_q;
	logic [SW-1:0] seq_q;
	logic [PW-1:0] pg_a, pg_b, page_d;
	logic [SW-1:0] seq_a, seq_b, seq_d, col;
	logic          restart, over, tick_cmd, last_col, last_page;
	logic [7:0]    cmd_byte;

	always_comb begin
		restart = 4'(page_q) >= pages_eff;
		pg_a    = restart ? '0 : page_q;
		seq_a   = restart ? '0 : seq_q;
		over    = seq_a >= (w_eff + SW'(3));
		if (over) begin
			seq_b = '0;
			pg_b  = ((4'(pg_a) + 4'd1) >= pages_eff) ? '0 : PW'(pg_a + PW'(1));
		end else begin
			seq_b = seq_a;
			pg_b  = pg_a;
		end
		tick_cmd  = seq_b < SEQ_FIRST_DATA;
		col       = seq_b - SEQ_FIRST_DATA;
		last_col  = seq_b == (w_eff + SW'(2));
		last_page = (4'(pg_b) + 4'd1) == pages_eff;

		if (seq_b == SEQ_CMD_PAGE)        cmd_byte = CMD_PAGE | {5'd0, 3'(pg_b)};
		else if (seq_b == SEQ_CMD_COL_LO) cmd_byte = CMD_COL_LOW;
		else                              cmd_byte = CMD_COL_HIGH;

		if (!tick_cmd && last_col) begin
			seq_d  = '0;
			page_d = last_page ? '0 : PW'(pg_b + PW'(1));
		end else begin
			seq_d  = seq_b + SW'(1);
			page_d = pg_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			seq_q  <= '0;
		end else if (cmd.take_tick) begin
			page_q <= page_d;
			seq_q  <= seq_d;
		end
	end

	// tick result fields, held until the next tick
	logic       is_cmd_s1, eop_s1, eof_s1;
	logic [7:0] cmd_byte_s1;

	always_ff @(posedge clk) begin
		if (cmd.take_tick) begin
			is_cmd_s1   <= tick_cmd;
			cmd_byte_s1 <= cmd_byte;
			eop_s1      <= !tick_cmd && last_col;
			eof_s1      <= !tick_cmd && last_col && last_page;
		end
	end

	// pixel decode
	logic [2:0]    pix_pg;
	logic          pix_ok;
	logic [AW-1:0] pix_addr, tick_addr;

	always_comb begin
		pix_pg    = pix_y[5:3];
		pix_ok    = (SW'(pix_x) < w_eff) && (4'(pix_pg) < pages_eff);
		pix_addr  = AW'(int'(PW'(pix_pg)) * MAX_WIDTH + int'(pix_x));
		tick_addr = AW'(int'(pg_b) * MAX_WIDTH + int'(col));
	end

	logic [AW-1:0] pix_addr_s1;
	logic [7:0]    pix_mask_s1;
	logic          pix_lit_s1, pix_ok_s1;

	always_ff @(posedge clk) begin
		if (cmd.take_pix) begin
			pix_addr_s1 <= pix_addr;
			pix_mask_s1 <= 8'b1 << pix_y[2:0];
			pix_lit_s1  <= (pixel_word & LIT_MASK) != 32'd0;
			pix_ok_s1   <= pix_ok;
		end
	end

	// clearing sweep
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign status.clear_last = clr_q == AW'(DEPTH - 1);

	// frame store: one read or one write per cycle
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	always_comb begin
		mem_re = cmd.take_pix || cmd.take_tick;
		raddr  = cmd.take_tick ? tick_addr : pix_addr;
		if (cmd.clear_wr) begin
			mem_we = 1'b1;
			waddr  = clr_q;
			wdata  = 8'd0;
		end else begin
			mem_we = cmd.pix_wr && pix_ok_s1;
			waddr  = pix_addr_s1;
			wdata  = pix_lit_s1 ? (rdata_q | pix_mask_s1) : (rdata_q & ~pix_mask_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	assign out_byte     = is_cmd_s1 ? cmd_byte_s1 : rdata_q;
	assign is_command   = is_cmd_s1;
	assign end_of_page  = eop_s1;
	assign end_of_frame = eof_s1;

endmodule

>>> sv/oled_page_framebuffer_packer_core.sv
// Channel   Direction  Signals                                   Handshake
// --------  ---------  ----------------------------------------  ------------------------------
// item      in         kind, pix_x, pix_y, pixel_word            beat taken when start && !busy
// result    out        out_byte, is_command, end_of_page,        one cycle, result_strobe high,
//                      end_of_frame                              no back-pressure
// config    in         cfg_we, cfg_index, cfg_data               written on any edge with cfg_we
//
// For every item the accept edge issues the frame-store read, and the
// following cycle does the write-back (pixel) or drives the result (tick), with
// busy high, as the single-port store needs a read-modify-write.
// A tick's result appears in the cycle right after its accept edge.
// After reset a clearing sweep zeroes all MAX_WIDTH * MAX_HEIGHT / 8 bytes of the
// store (1024 by default), one byte a cycle; busy stays high meanwhile.
// Results cannot be stalled; config writes are taken at any time.
module oled_page_framebuffer_packer_core import oledpf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item beat
	input  logic                 start,
	output logic                 busy,
	input  logic                 kind,
	input  logic [6:0]           pix_x,
	input  logic [5:0]           pix_y,
	input  logic [31:0]          pixel_word,
	// result beat
	output logic                 result_strobe,
	output logic [7:0]           out_byte,
	output logic                 is_command,
	output logic                 end_of_page,
	output logic                 end_of_frame,
	// config writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	oledpf_cmd_t    cmd;
	oledpf_status_t status;

	// sequencer: clear sweep, accept, write-back / emit
	oledpf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.busy          (busy),
		.result_strobe (result_strobe),
		.cmd           (cmd),
		.status        (status)
	);

	// frame store, stream position, config regs
	oledpf_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pix_x        (pix_x),
		.pix_y        (pix_y),
		.pixel_word   (pixel_word),
		.out_byte     (out_byte),
		.is_command   (is_command),
		.end_of_page  (end_of_page),
		.end_of_frame (end_of_frame)
	);

	// a tick beat always yields a result in the next cycle
	a_tick_emits: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind |=> result_strobe)
		else $error("tick accepted without a result");

	// no result without a preceding tick beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(start && !busy && kind))
		else $error("result without a tick");

	// frame end only on a data byte that also ends its page
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && end_of_frame |-> end_of_page && !is_command)
		else $error("end_of_frame on a non-final byte");

endmodule
